// ===== src/lucas_primality_test_defines.svh =====
`ifndef LUCAS_PRIMALITY_TEST_DEFINES_SVH
`define LUCAS_PRIMALITY_TEST_DEFINES_SVH

// same-cycle implication
`define LPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lpt_pkg.sv =====
package lpt_pkg;

  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned MaxFactorsDef = 10;
  localparam int unsigned CandWidth     = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FAC_TWO,
    ST_FAC_SQ,
    ST_FAC_SQ_CHK,
    ST_FAC_DIV,
    ST_FAC_REDIV,
    ST_FAC_TAIL,
    ST_BASE_START,
    ST_POW_STEP,
    ST_POW_GO,
    ST_POW_WAIT,
    ST_POW_END,
    ST_LUC_CHK,
    ST_LUC_DIV,
    ST_DONE
  } lpt_state_t;

endpackage

// ===== src/lucas_primality_test.sv =====
// Lucas primality tester.
// Pulse start with a candidate on candidate while busy is low; the word is
// taken at that edge and busy rises on the next cycle. Only the low
// VALUE_WIDTH bits of candidate are tested.
// One result word comes back: is_prime is valid for exactly one cycle while
// done is high, and busy falls in the cycle after. The receiver cannot stall.
// Candidates 0, 1, 2 and even ones go straight to the result state, so done
// rises in the cycle after the accepting edge. Odd candidates run trial
// division of n-1 and then modular powers per base; every modular product
// is a multiply step followed by a restoring reduction in the single shared
// divider. One candidate at a time.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// test in progress; no result is produced for it.
module lucas_primality_test
  import lpt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef,
  parameter int unsigned MAX_FACTORS = MaxFactorsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [CandWidth-1:0] candidate,
  output logic                 busy,
  output logic                 done,
  output logic                 is_prime
);

`include "lucas_primality_test_defines.svh"

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(MAX_FACTORS + 1);
  localparam int unsigned IW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;

  lpt_state_t     state, state_next;
  logic [W-1:0]   n, v, d, acc, base, expo, a;
  logic [2*W-1:0] prod;
  logic [W-1:0]   fac [MAX_FACTORS];
  logic [CW-1:0]  cnt, k;
  logic           rec, ph, fermat, res;

  logic           div_start, div_done;
  logic [2*W-1:0] div_dividend, div_q;
  logic [W-1:0]   div_divisor, div_r;
  logic [W-1:0]   n_in, fac_k;
  logic           sq_over;

  assign n_in    = candidate[W-1:0];
  assign fac_k   = fac[k[IW-1:0]];
  assign sq_over = (prod > {{W{1'b0}}, v});

  lpt_divider #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  always_comb begin
    div_dividend = prod;
    div_divisor  = n;
    div_start    = 1'b0;
    state_next   = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (n_in < W'(2) || n_in == W'(2) || !n_in[0]) state_next = ST_DONE;
          else state_next = ST_FAC_TWO;
        end
      end
      ST_FAC_TWO:    if (v[0]) state_next = ST_FAC_SQ;
      ST_FAC_SQ:     state_next = ST_FAC_SQ_CHK;
      ST_FAC_SQ_CHK: begin
        div_dividend = {{W{1'b0}}, v};
        div_divisor  = d;
        if (sq_over) state_next = ST_FAC_TAIL;
        else begin
          div_start  = 1'b1;
          state_next = ST_FAC_DIV;
        end
      end
      ST_FAC_DIV: begin
        if (div_done) begin
          if (div_r == '0) state_next = ST_FAC_REDIV;
          else state_next = ST_FAC_SQ;
        end
      end
      ST_FAC_REDIV: begin
        div_dividend = {{W{1'b0}}, v};
        div_divisor  = d;
        div_start    = 1'b1;
        state_next   = ST_FAC_DIV;
      end
      ST_FAC_TAIL:   state_next = ST_BASE_START;
      ST_BASE_START: state_next = (a == n) ? ST_DONE : ST_POW_STEP;
      ST_POW_STEP: begin
        if (!ph && expo == '0) state_next = ST_POW_END;
        else if (ph || expo[0]) state_next = ST_POW_GO;
      end
      ST_POW_GO: begin
        div_start  = 1'b1;
        state_next = ST_POW_WAIT;
      end
      ST_POW_WAIT:   if (div_done) state_next = ST_POW_STEP;
      ST_POW_END: begin
        if (fermat) state_next = (acc != W'(1)) ? ST_DONE : ST_LUC_CHK;
        else state_next = (acc == W'(1)) ? ST_BASE_START : ST_LUC_CHK;
      end
      ST_LUC_CHK: begin
        div_dividend = {{W{1'b0}}, n - W'(1)};
        div_divisor  = fac_k;
        if (k == cnt) state_next = ST_DONE;
        else begin
          div_start  = 1'b1;
          state_next = ST_LUC_DIV;
        end
      end
      ST_LUC_DIV:    if (div_done) state_next = ST_POW_STEP;
      ST_DONE:       state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n      <= n_in;
        v      <= n_in - W'(1);
        res    <= (n_in == W'(2));
        fac[0] <= W'(2);
        cnt    <= CW'(1);
      end
      ST_FAC_TWO: begin
        if (!v[0]) v <= v >> 1;
        else begin
          d   <= W'(3);
          rec <= 1'b0;
        end
      end
      ST_FAC_SQ: prod <= {{W{1'b0}}, d} * {{W{1'b0}}, d};
      ST_FAC_DIV: begin
        if (div_done) begin
          if (div_r == '0) begin
            v   <= div_q[W-1:0];
            rec <= 1'b1;
            if (!rec && cnt < CW'(MAX_FACTORS)) begin
              fac[cnt[IW-1:0]] <= d;
              cnt              <= cnt + 1'b1;
            end
          end else begin
            d   <= d + W'(2);
            rec <= 1'b0;
          end
        end
      end
      ST_FAC_TAIL: begin
        a <= W'(2);
        if (v > W'(2) && cnt < CW'(MAX_FACTORS)) begin
          fac[cnt[IW-1:0]] <= v;
          cnt              <= cnt + 1'b1;
        end
      end
      ST_BASE_START: begin
        res    <= 1'b0;
        expo   <= n - W'(1);
        acc    <= W'(1);
        base   <= a;
        ph     <= 1'b0;
        fermat <= 1'b1;
      end
      ST_POW_STEP: begin
        if (ph) prod <= {{W{1'b0}}, base} * {{W{1'b0}}, base};
        else if (expo != '0) begin
          if (expo[0]) prod <= {{W{1'b0}}, acc} * {{W{1'b0}}, base};
          else ph <= 1'b1;
        end
      end
      ST_POW_WAIT: begin
        if (div_done) begin
          if (!ph) begin
            acc <= div_r;
            ph  <= 1'b1;
          end else begin
            base <= div_r;
            expo <= expo >> 1;
            ph   <= 1'b0;
          end
        end
      end
      ST_POW_END: begin
        if (fermat) k <= '0;
        else if (acc == W'(1)) a <= a + W'(1);
        else k <= k + 1'b1;
        fermat <= 1'b0;
      end
      ST_LUC_CHK: if (k == cnt) res <= 1'b1;
      ST_LUC_DIV: begin
        if (div_done) begin
          expo <= div_q[W-1:0];
          acc  <= W'(1);
          base <= a;
          ph   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign busy     = (state != ST_IDLE);
  assign done     = (state == ST_DONE);
  assign is_prime = res;

  `LPT_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `LPT_ASSERT_NEXT(a_take_busy, start && !busy, busy, "busy not raised after accept")
  `LPT_ASSERT_NEXT(a_done_idle, done, !busy, "not idle after result")
  `LPT_ASSERT_NOW(a_div_quiet, div_done, state == ST_FAC_DIV || state == ST_POW_WAIT ||
    state == ST_LUC_DIV, "divider finished outside a wait state")

endmodule

// ===== src/lpt_divider.sv =====
module lpt_divider
  import lpt_pkg::*;
#(
  parameter int unsigned W = ValueWidthDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2*W-1:0] dividend,
  input  logic [W-1:0]   divisor,
  output logic           done,
  output logic [2*W-1:0] quotient,
  output logic [W-1:0]   remainder
);

  localparam int unsigned CntW = $clog2(2 * W + 1);

  logic            running;
  logic [CntW-1:0] cnt;
  logic [W-1:0]    dsr;
  logic [W-1:0]    rem;
  logic [2*W-1:0]  quo;
  logic [W:0]      sh;
  logic [W:0]      diff;
  logic            qbit;
  logic [W-1:0]    rem_next;

  always_comb begin
    sh       = {rem, quo[2*W-1]};
    diff     = sh - {1'b0, dsr};
    qbit     = (sh >= {1'b0, dsr});
    rem_next = qbit ? diff[W-1:0] : sh[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        rem     <= '0;
        quo     <= dividend;
        dsr     <= divisor;
        cnt     <= CntW'(2 * W);
      end else if (running) begin
        rem <= rem_next;
        quo <= {quo[2*W-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== test/testbench.sv =====
module testbench;
  import lpt_pkg::*;

  localparam int unsigned WatchLimit = 20000000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic [CandWidth-1:0] candidate;
  logic                 busy;
  logic                 done;
  logic                 is_prime;

  logic                 took;
  logic                 next_verdict;
  bit                   verdict_q[$];
  int unsigned          mismatches;
  int unsigned          words_in;
  int unsigned          words_out;
  int unsigned          primes_seen;
  int unsigned          quiet_cycles;

  lucas_primality_test u_dut (
    .clk(clk), .rst(rst), .start(start), .candidate(candidate),
    .busy(busy), .done(done), .is_prime(is_prime)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc;
    longint unsigned sq;
    acc = 1 % m;
    sq  = b % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit lucas_verdict(logic [CandWidth-1:0] word);
    longint unsigned n;
    longint unsigned v;
    longint unsigned d;
    longint unsigned a;
    longint unsigned fac[$];
    bit              all_ne;
    n = longint'(word);
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (!n[0]) return 1'b0;
    v = n - 1;
    if (!v[0]) begin
      fac = {fac, 64'd2};
      while (v != 0 && !v[0]) v = v >> 1;
    end
    for (d = 3; d * d <= v; d += 2) begin
      if (v % d == 0) begin
        if (fac.size() < MaxFactorsDef) fac = {fac, d};
        while (v % d == 0) v = v / d;
      end
    end
    if (v > 2 && fac.size() < MaxFactorsDef) fac = {fac, v};
    for (a = 2; a < n; a++) begin
      all_ne = 1'b1;
      if (pow_mod(a, n - 1, n) != 1) return 1'b0;
      foreach (fac[k]) begin
        if (pow_mod(a, (n - 1) / fac[k], n) == 1) begin
          all_ne = 1'b0;
          break;
        end
      end
      if (all_ne) return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (start && !busy) begin
        verdict_q = {verdict_q, next_verdict};
        words_in++;
      end
      if (done) begin
        words_out++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word is_prime=%0b", is_prime);
        end else begin
          if (verdict_q[0] !== is_prime) begin
            mismatches++;
            if (mismatches <= 10)
              $display("is_prime mismatch: expected %0b actual %0b", verdict_q[0], is_prime);
          end
          if (verdict_q[0]) primes_seen++;
          void'(verdict_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("watchdog: no activity for %0d cycles", WatchLimit);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [CandWidth-1:0] word, int known, int idle_pct);
    int gap;
    gap = 1;
    while ($urandom_range(99) < idle_pct) gap++;
    repeat (gap) @(negedge clk);
    next_verdict <= (known < 0) ? lucas_verdict(word) : known[0];
    start        <= 1'b1;
    candidate    <= word;
    do @(negedge clk); while (!took);
    start <= 1'b0;
  endtask

  typedef struct {
    logic [CandWidth-1:0] word;
    int                   known;
  } stim_row_t;

  stim_row_t   rows[] = '{
    '{32'd0, 0}, '{32'd1, 0}, '{32'd2, 1}, '{32'd3, 1}, '{32'd4, 0},
    '{32'hFFFF_FFFE, 0}, '{32'h8000_0000, 0}, '{32'd9, -1}, '{32'd15, -1},
    '{32'd25, -1}, '{32'd341, -1}, '{32'd561, -1}, '{32'd7919, -1},
    '{32'd65521, -1}, '{32'h8000_0001, -1}, '{32'd3221225473, -1},
    '{32'd2013265921, -1}, '{32'd97, -1}, '{32'd1105, -1}
  };
  int unsigned idle_by_phase[4] = '{0, 85, 0, 37};

  initial begin
    logic [CandWidth-1:0] word;
    int unsigned          pick;
    rst          = 1'b1;
    start        = 1'b0;
    candidate    = '0;
    next_verdict = 1'b0;
    mismatches   = 0;
    words_in     = 0;
    words_out    = 0;
    primes_seen  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send_word(rows[i].word, rows[i].known, 0);

    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 25; i++) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          word = {16'h0, 16'($urandom)};
        end else if (pick < 80) begin
          word = $urandom;
          word[0] = 1'b0;
        end else begin
          // value with smooth n-1 (odd unless the shift is zero): keeps trial division short
          word = (32'($urandom_range(127)) * 2 + 1) << $urandom_range(24);
          word = word + 1;
        end
        send_word(word, -1, idle_by_phase[ph]);
      end
    end

    while (verdict_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("%0d candidates tested, %0d answers, %0d prime, over four idling phases",
             words_in, words_out, primes_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/lpt_pkg.sv
src/lpt_divider.sv
src/lucas_primality_test.sv
test/testbench.sv
